// File: design/mbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbs_pkg
// shared constants for the metronome beat sequencer: pitch periods, limit
// tables, register map and field widths
// ----------------------------------------------------------------------------
package mbs_pkg;

    localparam int unsigned SOUND_NUM   = 100000;
    localparam int unsigned BEAT_NUM    = 60000000;
    localparam int unsigned TEMPO_RST   = 90;
    localparam int unsigned PERIOD_HIGH = 1276;
    localparam int unsigned PERIOD_MID  = 1517;
    localparam int unsigned PERIOD_LOW  = 2273;

    localparam int MAX_BEATS       = 16;
    localparam int NUM_PITCHES_DEF = 3;

    localparam int BPB_W       = 5;
    localparam int TEMPO_W     = 9;
    localparam int PATTERN_W   = 32;
    localparam int PERIOD_W    = 12;
    localparam int COMPARE_W   = 11;
    localparam int LEDS_W      = 4;
    localparam int NUMBER_W    = 5;
    localparam int TICK_W      = 16;
    localparam int BEAT_IDX_W  = 4;
    localparam int SLIMIT_W    = 7;
    localparam int BLIMIT_W    = 16;
    localparam int CODE_W      = 2;
    localparam int DIVISOR_W   = TEMPO_W + PERIOD_W;
    localparam int DIVIDEND_W  = $clog2(BEAT_NUM + 1);

    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [SLIMIT_W-1:0] t_slimit;
    typedef logic [BLIMIT_W-1:0] t_blimit;

    // pitch code 3 maps onto the low tone
    localparam t_period PITCH_PERIOD [4] = '{
        PERIOD_W'(PERIOD_HIGH), PERIOD_W'(PERIOD_MID),
        PERIOD_W'(PERIOD_LOW),  PERIOD_W'(PERIOD_LOW)
    };

    localparam t_slimit SOUND_LIMIT [4] = '{
        SLIMIT_W'(SOUND_NUM / PERIOD_HIGH), SLIMIT_W'(SOUND_NUM / PERIOD_MID),
        SLIMIT_W'(SOUND_NUM / PERIOD_LOW),  SLIMIT_W'(SOUND_NUM / PERIOD_LOW)
    };

    localparam t_blimit BEAT_LIMIT_RST [4] = '{
        BLIMIT_W'(BEAT_NUM / (TEMPO_RST * PERIOD_HIGH)),
        BLIMIT_W'(BEAT_NUM / (TEMPO_RST * PERIOD_MID)),
        BLIMIT_W'(BEAT_NUM / (TEMPO_RST * PERIOD_LOW)),
        BLIMIT_W'(BEAT_NUM / (TEMPO_RST * PERIOD_LOW))
    };

    // register map, word index
    localparam logic [1:0] REG_BPB     = 2'd0;
    localparam logic [1:0] REG_TEMPO   = 2'd1;
    localparam logic [1:0] REG_PATTERN = 2'd2;

    localparam logic [BPB_W-1:0]     BPB_RST     = BPB_W'(4);
    localparam logic [TEMPO_W-1:0]   TEMPO_RSTV  = TEMPO_W'(TEMPO_RST);
    localparam logic [PATTERN_W-1:0] PATTERN_RST = 32'hAAAA_AAA8;

endpackage : mbs_pkg
`default_nettype wire

// File: design/metronome_beat_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// metronome_beat_sequencer_top
// tick-driven metronome: tone compare/reload, beat leds and beat counting
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one request per timer tick; tdata[0] is the mute flag.
//   m_axis returns one result per tick: tone compare, tone reload, one-hot
//   beat led, beat number; tlast flags the tick that closed a beat.
//   the apb port holds beats per bar (0x0), tempo in bpm (0x4) and the
//   accent pattern (0x8); reads return the stored value, pready is tied high.
// latency and throughput
//   a tick's result is registered at the accepting edge and offered on
//   m_axis in the next cycle; one tick per cycle is sustained while the
//   divider is idle and m_axis is not held off, the work being one counter
//   increment and two compares against per-pitch limits. every write to a
//   mapped register reloads the beat limits through a shared restoring
//   divider, one quotient bit per cycle, pitches in turn; s_axis_tready
//   stays low while it runs and the next tick restarts the bar from beat one.
// reset
//   registers return to 4 beats, 90 bpm and the default pattern; the limit
//   tables hold their values for 90 bpm, so ticks are taken at once.
// stall
//   while m_axis is held off the result register keeps its request and a
//   further tick is taken only in a cycle where the result moves on.
// ----------------------------------------------------------------------------
module metronome_beat_sequencer_top #(
    parameter int NUM_PITCHES = mbs_pkg::NUM_PITCHES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] mute, [7:1] zero
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // tone_compare, tone_reload, beat_leds, beat_number
    output logic             m_axis_tlast,   // beat_advanced
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mbs_pkg::*;

    localparam int PIDX_W = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;
    localparam int CNT_W  = $clog2(DIVIDEND_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    localparam logic [PIDX_W-1:0]     LAST_PITCH = PIDX_W'(NUM_PITCHES - 1);
    localparam logic [CODE_W-1:0]     LAST_CODE  = CODE_W'(NUM_PITCHES - 1);
    localparam logic [CNT_W-1:0]      LAST_STEP  = CNT_W'(DIVIDEND_W - 1);
    localparam logic [DIVIDEND_W-1:0] DIVIDEND   = DIVIDEND_W'(BEAT_NUM);

    // configuration registers
    logic [BPB_W-1:0]     r_bpb;
    logic [TEMPO_W-1:0]   r_tempo;
    logic [PATTERN_W-1:0] r_pattern;

    // sequencer state
    logic [TICK_W-1:0]     r_tick;
    logic [BEAT_IDX_W-1:0] r_beat;
    logic                  r_restart;
    logic [PERIOD_W-1:0]   r_last_reload;
    t_blimit               r_blimit [NUM_PITCHES];

    // limit divider
    logic [1:0]            r_state;
    logic [PIDX_W-1:0]     r_pitch;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    // result register
    logic                  r_out_valid;
    logic [COMPARE_W-1:0]  r_compare;
    logic [PERIOD_W-1:0]   r_reload;
    logic [LEDS_W-1:0]     r_leds;
    logic [NUMBER_W-1:0]   r_number;
    logic                  r_adv;

    logic cfg_wr;
    logic cfg_hit;
    logic tick_take;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_wr && (paddr[3:2] == REG_BPB || paddr[3:2] == REG_TEMPO
                                || paddr[3:2] == REG_PATTERN);

    always_comb begin
        case (paddr[3:2])
            REG_BPB:     prdata = 32'(r_bpb);
            REG_TEMPO:   prdata = 32'(r_tempo);
            REG_PATTERN: prdata = r_pattern;
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpb     <= BPB_RST;
            r_tempo   <= TEMPO_RSTV;
            r_pattern <= PATTERN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BPB:     r_bpb     <= pwdata[BPB_W-1:0];
                REG_TEMPO:   r_tempo   <= pwdata[TEMPO_W-1:0];
                REG_PATTERN: r_pattern <= pwdata;
                default:     ;
            endcase
        end
    end

    // ---------------- beat limit divider ----------------
    // 60e6 / (bpm * period), one quotient bit per cycle, pitches in turn
    logic [TEMPO_W-1:0]   bpm_eff;
    logic [DIVISOR_W:0]   rem_shift;
    logic                 quo_bit;
    logic [DIVISOR_W:0]   rem_diff;
    logic [DIVIDEND_W-1:0] quo_next;

    assign bpm_eff   = (r_tempo == '0) ? TEMPO_W'(1) : r_tempo;
    assign rem_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign quo_bit   = rem_shift >= {1'b0, r_divisor};
    assign rem_diff  = rem_shift - {1'b0, r_divisor};
    assign quo_next  = {r_quo[DIVIDEND_W-2:0], quo_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pitch <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < NUM_PITCHES; i++) begin
                r_blimit[i] <= BEAT_LIMIT_RST[i];
            end
        end else if (cfg_hit) begin
            // a fresh write restarts the whole reload
            r_state <= ST_MUL;
            r_pitch <= '0;
        end else begin
            case (r_state)
                ST_MUL: begin
                    r_state <= ST_DIV;
                    r_cnt   <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == LAST_STEP) begin
                        r_blimit[r_pitch] <= quo_next[BLIMIT_W-1:0];
                        if (r_pitch == LAST_PITCH) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_pitch <= r_pitch + PIDX_W'(1);
                            r_state <= ST_MUL;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_divisor <= DIVISOR_W'(bpm_eff) * DIVISOR_W'(PITCH_PERIOD[CODE_W'(r_pitch)]);
            r_rem     <= '0;
            r_quo     <= DIVIDEND;
        end else if (r_state == ST_DIV) begin
            r_rem <= quo_bit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            r_quo <= quo_next;
        end
    end

    // ---------------- per tick work ----------------
    logic [TICK_W-1:0]     tick_base;
    logic [TICK_W-1:0]     tick_inc;
    logic [BEAT_IDX_W-1:0] beat_base;
    logic [CODE_W-1:0]     code_raw;
    logic [CODE_W-1:0]     code;
    t_period               period;
    t_slimit               slimit;
    t_blimit               blimit;
    logic [BPB_W-1:0]      bpb_eff;
    logic [BPB_W-1:0]      beat_inc;
    logic [BEAT_IDX_W-1:0] beat_next;
    logic                  in_sound;
    logic                  in_beat;

    assign tick_base = r_restart ? '0 : r_tick;
    assign beat_base = r_restart ? '0 : r_beat;
    assign tick_inc  = tick_base + TICK_W'(1);
    assign code_raw  = r_pattern[{beat_base, 1'b0} +: CODE_W];
    assign code      = (code_raw == 2'd3 || 32'(code_raw) >= 32'(NUM_PITCHES))
                       ? LAST_CODE : code_raw;
    assign period    = PITCH_PERIOD[code];
    assign slimit    = SOUND_LIMIT[code];
    assign blimit    = r_blimit[code[PIDX_W-1:0]];
    assign in_sound  = tick_inc <= TICK_W'(slimit);
    assign in_beat   = tick_inc <= blimit;

    assign bpb_eff   = (r_bpb == '0) ? BPB_W'(1)
                     : (r_bpb > BPB_W'(MAX_BEATS)) ? BPB_W'(MAX_BEATS) : r_bpb;
    assign beat_inc  = BPB_W'(beat_base) + BPB_W'(1);
    assign beat_next = (beat_inc >= bpb_eff) ? '0 : beat_inc[BEAT_IDX_W-1:0];

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign tick_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_beat        <= '0;
            r_restart     <= 1'b0;
            r_last_reload <= '0;
        end else begin
            // a write in the cycle of a tick arms the restart after that tick
            if (cfg_hit) begin
                r_restart <= 1'b1;
            end else if (tick_take) begin
                r_restart <= 1'b0;
            end
            if (tick_take) begin
                if (in_sound || in_beat) begin
                    r_tick        <= tick_inc;
                    r_beat        <= beat_base;
                    r_last_reload <= period;
                end else begin
                    r_tick <= '0;
                    r_beat <= beat_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_take) begin
            if (in_sound) begin
                r_compare <= s_axis_tdata[0] ? '0 : period[PERIOD_W-1:1];
                r_reload  <= period;
                r_leds    <= LEDS_W'(1) << beat_base[1:0];
                r_number  <= BPB_W'(beat_base) + BPB_W'(1);
                r_adv     <= 1'b0;
            end else if (in_beat) begin
                r_compare <= '0;
                r_reload  <= period;
                r_leds    <= '0;
                r_number  <= BPB_W'(beat_base) + BPB_W'(1);
                r_adv     <= 1'b0;
            end else begin
                // beat closes: silence, previous reload held
                r_compare <= '0;
                r_reload  <= r_last_reload;
                r_leds    <= '0;
                r_number  <= BPB_W'(beat_next) + BPB_W'(1);
                r_adv     <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_number, r_leds, r_reload, r_compare};
    assign m_axis_tlast  = r_adv;

    // ---------------- assertions ----------------
    a_cfg_blocks_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> !s_axis_tready)
        else $error("tick accepted while beat limits reload");

    a_beat_in_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_restart |-> (BPB_W'(r_beat) < bpb_eff))
        else $error("beat index outside the bar");

    a_advance_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (r_leds == '0 && r_compare == '0))
        else $error("beat end result not silent");

    a_div_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= LAST_STEP))
        else $error("divider step counter overran");

    a_result_taken_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_take |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

endmodule : metronome_beat_sequencer_top
`default_nettype wire

// File: test/metronome_beat_checker.sv
// ----------------------------------------------------------------------------
// metronome_beat_checker
// watches the tick, result and register ports of the metronome sequencer,
// predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module metronome_beat_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick_valid,
    input  logic        i_tick_ready,
    input  logic [7:0]  i_tick_data,    // [0] mute, [7:1] zero
    input  logic        i_result_valid,
    input  logic        i_result_ready,
    input  logic [31:0] i_result_data,  // compare, reload, leds, number
    input  logic        i_result_last,  // beat advanced
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    output int          o_pending,
    output int          o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import mbs_pkg::*;

    localparam int NUM_TONES = NUM_PITCHES_DEF;

    localparam t_period TONE_PERIOD [4] = '{
        PERIOD_W'(PERIOD_HIGH), PERIOD_W'(PERIOD_MID),
        PERIOD_W'(PERIOD_LOW),  PERIOD_W'(PERIOD_LOW)
    };

    // same order as the result bus, compare in the low bits
    typedef struct packed {
        logic [NUMBER_W-1:0]  number;
        logic [LEDS_W-1:0]    leds;
        logic [PERIOD_W-1:0]  reload;
        logic [COMPARE_W-1:0] compare;
    } t_beat_word;

    typedef struct {
        t_beat_word word;
        logic       advanced;
    } t_tick_result;

    logic [BPB_W-1:0]      cfg_bpb;
    logic [TEMPO_W-1:0]    cfg_tempo;
    logic [PATTERN_W-1:0]  cfg_pattern;
    logic [TICK_W-1:0]     tick_cnt;
    logic [BEAT_IDX_W-1:0] beat_idx;
    logic                  restart_armed;
    t_slimit               sound_lim [4];
    t_blimit               beat_lim [4];
    t_period               prev_reload;

    t_tick_result tick_results_due [$];
    int           failures = 0;

    assign o_failures = failures;

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void recompute_limits();
        int unsigned bpm;
        bpm = (cfg_tempo == '0) ? 1 : int'(cfg_tempo);
        for (int p = 0; p < NUM_TONES; p++) begin
            sound_lim[p] = SLIMIT_W'(SOUND_NUM / TONE_PERIOD[p]);
            beat_lim[p]  = BLIMIT_W'(BEAT_NUM / (bpm * TONE_PERIOD[p]));
        end
    endfunction

    // one tick of the metronome: sound phase, silent phase, or beat end
    function automatic t_tick_result advance_metronome(input logic mute);
        t_tick_result r;
        logic [CODE_W-1:0] code;
        t_period per;
        int unsigned span;
        r.word = '0;
        r.advanced = 1'b0;
        if (restart_armed) begin
            tick_cnt = '0;
            beat_idx = '0;
            restart_armed = 1'b0;
        end
        tick_cnt = tick_cnt + 1'b1;
        code = cfg_pattern[{beat_idx, 1'b0} +: CODE_W];
        if (code >= NUM_TONES) code = CODE_W'(NUM_TONES - 1);
        per = TONE_PERIOD[code];
        if (tick_cnt <= sound_lim[code]) begin
            r.word.compare = mute ? '0 : COMPARE_W'(per >> 1);
            r.word.reload  = per;
            r.word.leds    = LEDS_W'(1) << beat_idx[1:0];
            prev_reload    = per;
        end else if (tick_cnt <= beat_lim[code]) begin
            r.word.reload = per;
            prev_reload   = per;
        end else begin
            span = (cfg_bpb == '0) ? 1 : (cfg_bpb > MAX_BEATS) ? MAX_BEATS : int'(cfg_bpb);
            tick_cnt      = '0;
            beat_idx      = BEAT_IDX_W'((beat_idx + 1) % span);
            r.word.reload = prev_reload;
            r.advanced    = 1'b1;
        end
        r.word.number = NUMBER_W'(beat_idx) + NUMBER_W'(1);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tick_result want, got;
        logic [31:0]  want_reg;
        logic         mapped;
        if (!i_rst_n) begin
            cfg_bpb       = BPB_RST;
            cfg_tempo     = TEMPO_RSTV;
            cfg_pattern   = PATTERN_RST;
            tick_cnt      = '0;
            beat_idx      = '0;
            restart_armed = 1'b0;
            prev_reload   = '0;
            recompute_limits();
            tick_results_due.delete();
        end else begin
            if (i_result_valid && i_result_ready) begin
                got.word     = i_result_data;
                got.advanced = i_result_last;
                if (tick_results_due.size() == 0) begin
                    note_failure($sformatf("result %h/%b with no tick waiting",
                                           i_result_data, i_result_last));
                end else begin
                    want = tick_results_due.pop_front();
                    if (got.word.compare !== want.word.compare ||
                        got.word.reload  !== want.word.reload  ||
                        got.word.leds    !== want.word.leds    ||
                        got.word.number  !== want.word.number  ||
                        got.advanced     !== want.advanced)
                        note_failure($sformatf({"compare %0d/%0d reload %0d/%0d ",
                            "leds %b/%b number %0d/%0d advanced %b/%b (expected/actual)"},
                            want.word.compare, got.word.compare,
                            want.word.reload, got.word.reload,
                            want.word.leds, got.word.leds,
                            want.word.number, got.word.number,
                            want.advanced, got.advanced));
                end
            end
            if (i_tick_valid && i_tick_ready)
                tick_results_due.push_back(advance_metronome(i_tick_data[0]));
            // register write: any mapped write recomputes and restarts the bar
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                mapped = 1'b1;
                case (i_paddr[3:2])
                    REG_BPB:     cfg_bpb     = i_pwdata[BPB_W-1:0];
                    REG_TEMPO:   cfg_tempo   = i_pwdata[TEMPO_W-1:0];
                    REG_PATTERN: cfg_pattern = i_pwdata[PATTERN_W-1:0];
                    default:     mapped      = 1'b0;
                endcase
                if (mapped) begin
                    recompute_limits();
                    restart_armed = 1'b1;
                end
            end
            if (i_psel && i_penable && !i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_BPB:     want_reg = 32'(cfg_bpb);
                    REG_TEMPO:   want_reg = 32'(cfg_tempo);
                    REG_PATTERN: want_reg = cfg_pattern;
                    default:     want_reg = i_prdata;
                endcase
                if (i_prdata !== want_reg)
                    note_failure($sformatf("read at 0x%0h: expected %h, got %h",
                                           i_paddr, want_reg, i_prdata));
            end
        end
        o_pending <= tick_results_due.size();
    end

endmodule : metronome_beat_checker

// File: test/metronome_beat_sequencer_top_test.sv
// ----------------------------------------------------------------------------
// metronome_beat_sequencer_top_test
// drives timer ticks and register settings into the metronome sequencer with
// random gaps and result back-pressure; a side checker predicts each result
// ----------------------------------------------------------------------------
module metronome_beat_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbs_pkg::*;

    // word index past the register map, writes there must be dropped
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    // cycles with no request moving on any port before giving up
    localparam int QUIET_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [0] mute, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;      // compare, reload, leds, number
    logic        m_axis_tlast;      // beat advanced
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int results_pending;
    int failures;
    int ready_hold  = 0;
    int quiet_cycles = 0;
    bit tick_gaps_on = 1'b0;

    metronome_beat_sequencer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    metronome_beat_checker beat_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (s_axis_tvalid),
        .i_tick_ready   (s_axis_tready),
        .i_tick_data    (s_axis_tdata),
        .i_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready),
        .i_result_data  (m_axis_tdata),
        .i_result_last  (m_axis_tlast),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .o_pending      (results_pending),
        .o_failures     (failures)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result back-pressure: short stalls, rare long ones, and long open stretches
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold    <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(0, 12);
        end
    end

    // watchdog on cycles in which nothing is accepted anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_access(input logic write, input logic [1:0] index,
                              input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // the limit divider holds the tick port off until it is done
    task automatic wait_settled();
        repeat (2) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // close the burst and wait for every result to come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_tick(input logic mute);
        int gap;
        gap = tick_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, mute};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // write all three registers one at a time, then read them back
    task automatic load_setting(input logic [BPB_W-1:0] bpb, input logic [TEMPO_W-1:0] bpm,
                                input logic [PATTERN_W-1:0] pattern);
        apb_access(1'b1, REG_BPB, 32'(bpb));
        wait_settled();
        apb_access(1'b1, REG_TEMPO, 32'(bpm));
        wait_settled();
        apb_access(1'b1, REG_PATTERN, pattern);
        wait_settled();
        apb_access(1'b0, REG_BPB, '0);
        apb_access(1'b0, REG_TEMPO, '0);
        apb_access(1'b0, REG_PATTERN, '0);
    endtask

    task automatic random_ticks(input int count);
        tick_gaps_on = ($urandom_range(0, 3) != 0);
        repeat (count) send_tick(1'($urandom_range(0, 1)));
        wait_drained();
    endtask

    initial begin
        logic [BPB_W-1:0] bpb;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values read back, then the default bar starts at once,
        // some ticks muted during the sound phase
        apb_access(1'b0, REG_BPB, '0);
        apb_access(1'b0, REG_TEMPO, '0);
        apb_access(1'b0, REG_PATTERN, '0);
        for (int i = 0; i < 8; i++) send_tick(i % 3 == 1);
        wait_drained();

        // write past the map: no restart, the count carries on
        apb_access(1'b1, REG_UNMAPPED, $urandom());
        wait_settled();
        for (int i = 0; i < 3; i++) send_tick(1'b0);
        wait_drained();

        // zero tempo and zero beats per bar, every pitch code three
        load_setting('0, '0, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) send_tick(i[0]);
        wait_drained();

        // a fast tempo, full bar, all high pitch
        tick_gaps_on = 1'b1;
        load_setting(BPB_W'(MAX_BEATS), TEMPO_W'(300), '0);
        for (int i = 0; i < 6; i++) send_tick(i[1]);
        wait_drained();

        // slowest tempo, single beat bar, all mid pitch
        load_setting(BPB_W'(1), TEMPO_W'(1), 32'h5555_5555);
        for (int i = 0; i < 4; i++) send_tick(i[0]);
        wait_drained();

        // quick tempos with arbitrary patterns and bar lengths, short runs
        repeat (2) begin
            bpb = ($urandom_range(0, 1) == 0) ? BPB_W'($urandom_range(0, 3))
                                              : BPB_W'($urandom_range(4, 31));
            load_setting(bpb, TEMPO_W'($urandom_range(400, 511)), $urandom());
            random_ticks($urandom_range(30, 60));
        end

        // sixteen short low beats so the index runs through and wraps,
        // beats per bar at or above the maximum
        load_setting(BPB_W'($urandom_range(MAX_BEATS, 31)),
                     TEMPO_W'(511), $urandom() | 32'hAAAA_AAAA);
        random_ticks(840);

        repeat (8) @(posedge i_clk);
        if (failures == 0 && results_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : metronome_beat_sequencer_top_test
